// ===== src/bms_response_frame_deframer_unit_assert.svh =====
// assertion macros for the response frame deframer
`ifndef BMS_RESPONSE_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define BMS_RESPONSE_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define BRFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication
`define BRFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ===== src/bms_rfd_pkg.sv =====
`timescale 1ns / 1ps

package bms_rfd_pkg;

  localparam logic [7:0] StartByte = 8'hDD;
  localparam logic [7:0] ErrorMask = 8'h80;
  localparam logic [7:0] EndByte   = 8'h77;

  // verdict bit positions
  localparam int unsigned VerdictBadEnd = 0;
  localparam int unsigned VerdictBadSum = 1;

  typedef enum logic [8:0] {
    PH_HUNT    = 9'b000000001,
    PH_CMD     = 9'b000000010,
    PH_STATUS  = 9'b000000100,
    PH_LEN     = 9'b000001000,
    PH_PAYLOAD = 9'b000010000,
    PH_SUM_HI  = 9'b000100000,
    PH_SUM_LO  = 9'b001000000,
    PH_END     = 9'b010000000,
    PH_DONE    = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic       is_frame_end;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic       device_error;
    logic [1:0] verdict;
  } out_item_t;

  // result handed from parser to output buffer
  typedef struct packed {
    logic      push;
    out_item_t item;
  } res_push_t;

endpackage

// ===== src/bms_rfd_parser.sv =====
`timescale 1ns / 1ps

module bms_rfd_parser
  import bms_rfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  in_item_t  item_i,
  output res_push_t res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic        err_q, err_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] run_q, run_d;
  logic [15:0] rcv_q, rcv_d;

  phase_e      phase_eff;
  logic [7:0]  c;
  logic [7:0]  cnt_inc;
  logic [15:0] run_sub;

  assign c         = item_i.rx_byte;
  assign phase_eff = item_i.restart ? PH_HUNT : phase_q;
  assign cnt_inc   = cnt_q + 8'd1;
  assign run_sub   = run_q - {8'h00, c};

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    err_d   = err_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    rcv_d   = rcv_q;
    res_o.push               = 1'b0;
    res_o.item.is_frame_end  = 1'b0;
    res_o.item.payload_byte  = 8'h00;
    res_o.item.payload_index = 8'h00;
    res_o.item.frame_command = cmd_q;
    res_o.item.frame_length  = len_q;
    res_o.item.device_error  = err_q;
    res_o.item.verdict       = 2'b00;
    if (take_i) begin
      phase_d = phase_eff;
      case (phase_eff)
        PH_HUNT: begin
          if (c == StartByte) phase_d = PH_CMD;
        end
        PH_CMD: begin
          cmd_d   = c;
          phase_d = PH_STATUS;
        end
        PH_STATUS: begin
          err_d   = |(c & ErrorMask);
          run_d   = 16'h0000 - {8'h00, c};
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          len_d   = c;
          cnt_d   = 8'h00;
          run_d   = run_sub;
          phase_d = (c == 8'h00) ? PH_SUM_HI : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          run_d = run_sub;
          cnt_d = cnt_inc;
          res_o.push               = 1'b1;
          res_o.item.payload_byte  = c;
          res_o.item.payload_index = cnt_q;
          if (cnt_inc >= len_q) phase_d = PH_SUM_HI;
        end
        PH_SUM_HI: begin
          rcv_d   = {c, 8'h00};
          phase_d = PH_SUM_LO;
        end
        PH_SUM_LO: begin
          rcv_d   = {rcv_q[15:8], c};
          phase_d = PH_END;
        end
        PH_END: begin
          res_o.push                            = 1'b1;
          res_o.item.is_frame_end               = 1'b1;
          res_o.item.verdict[VerdictBadEnd]     = (c != EndByte);
          res_o.item.verdict[VerdictBadSum]     = (rcv_q != run_q);
          phase_d                               = PH_DONE;
        end
        default: begin
          // done, or a code that means nothing: ignore the byte
          phase_d = phase_eff;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cmd_q   <= 8'h00;
      err_q   <= 1'b0;
      len_q   <= 8'h00;
      cnt_q   <= 8'h00;
      run_q   <= 16'h0000;
      rcv_q   <= 16'h0000;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      err_q   <= err_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      run_q   <= run_d;
      rcv_q   <= rcv_d;
    end
  end

endmodule

// ===== src/bms_rfd_out_buf.sv =====
`timescale 1ns / 1ps

module bms_rfd_out_buf
  import bms_rfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t res_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      main_valid_q;
  logic      skid_valid_q;
  out_item_t main_q;
  out_item_t skid_q;
  logic      take;

  assign take        = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_item_o  = main_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) skid_valid_q <= 1'b0;
    end else if (res_i.push) begin
      if (main_valid_q && !take) skid_valid_q <= 1'b1;
      else main_valid_q <= 1'b1;
    end else if (take) begin
      main_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) main_q <= skid_q;
    end else if (res_i.push) begin
      if (main_valid_q && !take) skid_q <= res_i.item;
      else main_q <= res_i.item;
    end
  end

endmodule

// ===== src/bms_response_frame_deframer_unit.sv =====
`timescale 1ns / 1ps

// channel | direction | payload    | handshake
// --------+-----------+------------+------------------------------------
// in      | receive   | in_item_t  | in_valid_i / in_stall_o
// out     | send      | out_item_t | out_valid_o / out_stall_i
//
// one received byte per cycle unless in_stall_o is high: each transfer updates
// the parser state in the cycle it is accepted; any result is registered in
// the output register, or in the one-entry skid stage when that register holds
// an untaken result; input transfers carry on while a result waits; in_stall_o
// rises only once the skid is full and is a plain register output
// reset (rst_ni low, asynchronous) returns the parser to start-byte hunt and
// empties both output entries

module bms_response_frame_deframer_unit
  import bms_rfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      in_take;
  logic      buf_full;
  res_push_t res;

  // a transfer happens whenever the skid stage has room
  assign in_stall_o = buf_full;
  assign in_take    = in_valid_i && !buf_full;

  // frame parser: phase, held header fields and checksum accumulation
  bms_rfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (in_take),
    .item_i (in_item_i),
    .res_o  (res)
  );

  // output register plus skid entry
  bms_rfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== src/bms_rfd_checker.sv =====
`timescale 1ns / 1ps

`include "bms_response_frame_deframer_unit_assert.svh"

module bms_rfd_checker
  import bms_rfd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  `BRFD_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_item_i))
  `BRFD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  `BRFD_ASSERT_NOW(a_stall_needs_out, in_stall_o, out_valid_o)
  `BRFD_ASSERT_NOW(a_end_clean, out_valid_o && out_item_o.is_frame_end,
    out_item_o.payload_byte == 8'h00 && out_item_o.payload_index == 8'h00)
  `BRFD_ASSERT_NOW(a_payload_no_verdict, out_valid_o && !out_item_o.is_frame_end,
    out_item_o.verdict == 2'b00)

endmodule

bind bms_response_frame_deframer_unit bms_rfd_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== tb/sv/tb_bms_response_frame_deframer_unit.sv =====
`timescale 1ns / 1ps

module tb_bms_response_frame_deframer_unit;
  import bms_rfd_pkg::*;

  localparam int unsigned RandomItems   = 1200;
  localparam int unsigned HoldOffCycles = 120;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned CycleLimit    = 500000;

  // frame parser shadow plus the queue of results still owed by the block
  class frame_scoreboard;
    phase_e      phase;
    logic [7:0]  held_cmd;
    logic [7:0]  held_len;
    logic [7:0]  pay_count;
    logic        held_err;
    logic [15:0] neg_sum;
    logic [15:0] rx_sum;
    out_item_t   owed_q[$];
    int unsigned errors;

    function new();
      phase     = PH_HUNT;
      held_cmd  = '0;
      held_len  = '0;
      pay_count = '0;
      held_err  = 1'b0;
      neg_sum   = '0;
      rx_sum    = '0;
      errors    = 0;
    endfunction

    // advance the shadow parser by one accepted byte
    function void note_byte(in_item_t it);
      logic [7:0] c;
      out_item_t  r;
      bit         produce;
      c       = it.rx_byte;
      r       = '0;
      produce = 1'b0;
      if (it.restart) phase = PH_HUNT;
      case (phase)
        PH_HUNT: begin
          if (c == StartByte) phase = PH_CMD;
        end
        PH_CMD: begin
          held_cmd = c;
          phase    = PH_STATUS;
        end
        PH_STATUS: begin
          held_err = (c & ErrorMask) != 8'h00;
          neg_sum  = 16'h0000 - {8'h00, c};
          phase    = PH_LEN;
        end
        PH_LEN: begin
          held_len  = c;
          pay_count = 8'h00;
          neg_sum   = neg_sum - {8'h00, c};
          phase     = (c == 8'h00) ? PH_SUM_HI : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          neg_sum         = neg_sum - {8'h00, c};
          r.payload_byte  = c;
          r.payload_index = pay_count;
          produce         = 1'b1;
          pay_count       = pay_count + 8'h01;
          if (pay_count >= held_len) phase = PH_SUM_HI;
        end
        PH_SUM_HI: begin
          rx_sum = {c, 8'h00};
          phase  = PH_SUM_LO;
        end
        PH_SUM_LO: begin
          rx_sum = rx_sum + {8'h00, c};
          phase  = PH_END;
        end
        PH_END: begin
          r.is_frame_end           = 1'b1;
          r.verdict[VerdictBadEnd] = c != EndByte;
          r.verdict[VerdictBadSum] = rx_sum != neg_sum;
          produce                  = 1'b1;
          phase                    = PH_DONE;
        end
        default: ;
      endcase
      if (produce) begin
        r.frame_command = held_cmd;
        r.frame_length  = held_len;
        r.device_error  = held_err;
        owed_q.insert(owed_q.size(), r);
      end
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("deframer result check: %s", what);
    endfunction

    function void field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) report($sformatf("%s expected %0h actual %0h", name, want, got));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = owed_q.pop_front();
      field("is_frame_end",  8'(want.is_frame_end),  8'(got.is_frame_end));
      field("payload_byte",  want.payload_byte,      got.payload_byte);
      field("payload_index", want.payload_index,     got.payload_index);
      field("frame_command", want.frame_command,     got.frame_command);
      field("frame_length",  want.frame_length,      got.frame_length);
      field("device_error",  8'(want.device_error),  8'(got.device_error));
      field("verdict",       8'(want.verdict),       8'(got.verdict));
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  frame_scoreboard sb = new();

  // payload of the frame about to be sent
  logic [7:0]  frame_body[$];
  int unsigned frame_items   = 0;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int unsigned hold_off_asks = 0;
  // when set, the sender offers back to back with no gaps
  bit          steady        = 1'b0;

  bms_response_frame_deframer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // both handshakes sampled at the edge, before the block's registers move
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    end
  end

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned sender_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one byte and hold it until the transfer happens
  task automatic send_item(input logic [7:0] b, input logic rs);
    in_item_t    it;
    int unsigned gap;
    it.rx_byte = b;
    it.restart = rs;
    gap        = sender_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // build a frame around frame_body; sum_flip and end_code spoil it on purpose,
  // cut stops after that many bytes (negative sends the whole frame)
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] status,
                            input logic [15:0] sum_flip, input logic [7:0] end_code,
                            input logic lead_rs, input int cut);
    logic [7:0]  line_q[$];
    logic [7:0]  len;
    logic [15:0] sum;
    len = 8'(frame_body.size());
    sum = 16'h0000 - {8'h00, status} - {8'h00, len};
    foreach (frame_body[i]) sum = sum - {8'h00, frame_body[i]};
    sum    = sum ^ sum_flip;
    line_q = {StartByte, cmd, status, len};
    foreach (frame_body[i]) line_q = {line_q, frame_body[i]};
    line_q = {line_q, sum[15:8], sum[7:0], end_code};
    foreach (line_q[i]) begin
      if (cut >= 0 && i >= cut) break;
      send_item(line_q[i], (i == 0) ? lead_rs : 1'b0);
      frame_items++;
    end
  endtask

  // receiver: random stall stretches, with a long hold-off on request
  initial begin : receiver
    int unsigned span;
    int unsigned seen;
    logic        level;
    span  = 0;
    seen  = 0;
    level = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_off_asks != seen) begin
        seen  = hold_off_asks;
        level = 1'b1;
        span  = HoldOffCycles;
      end else if (span == 0) begin
        if ($urandom_range(0, 99) < 25) begin
          level = 1'b1;
          span  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          span  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
        end
      end
      out_stall_i <= level;
      span--;
      @(posedge clk_i);
    end
  end

  // hard stop on a hung run
  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("bms_response_frame_deframer_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned roll;
    int unsigned len;
    int unsigned big_frames;
    bit          pressed;
    logic [7:0]  cmd;
    logic [7:0]  status;
    big_frames = 0;
    pressed    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero length, device error set, extreme command, clean frame
    frame_body = {};
    send_frame(8'hFF, 8'h80, 16'h0000, EndByte, 1'b1, -1);
    // payload extremes, bad end byte together with bad checksum
    frame_body = {8'h00, 8'hFF};
    send_frame(8'h00, 8'h7F, 16'h0001, 8'h00, 1'b1, -1);
    // start byte after frame end without restart: must be ignored
    send_item(StartByte, 1'b0);
    // frame abandoned after the status byte, then restart into a new frame
    frame_body = {8'h5A};
    send_frame(8'h12, 8'h01, 16'h0000, EndByte, 1'b1, 3);
    // bad checksum only
    send_frame(8'h34, 8'hFF, 16'h8000, EndByte, 1'b1, -1);

    // random: mostly well-formed frames, some spoilt, cut short or noise
    while (frame_items < RandomItems) begin
      roll   = $urandom_range(0, 99);
      steady = ($urandom_range(0, 4) == 0);
      if (!pressed && frame_items > 400) begin
        // long payload while the receiver holds off, so the block backs up
        pressed       = 1'b1;
        len           = 60;
        roll          = 0;
        hold_off_asks <= hold_off_asks + 1;
      end else if (big_frames < 2 && $urandom_range(0, 149) == 0) begin
        len = 255;
        big_frames++;
      end else if ($urandom_range(0, 6) == 0) begin
        len = $urandom_range(9, 40);
      end else begin
        len = $urandom_range(0, 8);
      end
      frame_body = {};
      repeat (len) frame_body = {frame_body, 8'($urandom)};
      cmd    = 8'($urandom);
      status = 8'($urandom);
      if (roll < 70) begin
        send_frame(cmd, status, 16'h0000, EndByte, 1'b1, -1);
      end else if (roll < 85) begin
        send_frame(cmd, status,
                   ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'h0000,
                   ($urandom_range(0, 1) == 0) ? 8'($urandom) : EndByte,
                   $urandom_range(0, 9) != 0, -1);
      end else if (roll < 93) begin
        send_frame(cmd, status, 16'h0000, EndByte, 1'b1, $urandom_range(1, len + 6));
      end else begin
        // line noise, with stray restarts and start bytes
        repeat ($urandom_range(1, 6))
          send_item(($urandom_range(0, 3) == 0) ? StartByte : 8'($urandom),
                    $urandom_range(0, 4) == 0);
      end
    end
    in_valid_i <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk_i);
    // catch any stray result after the last expected one
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("bms_response_frame_deframer_unit: match");
    end else begin
      $display("bms_response_frame_deframer_unit: mismatch");
    end
    $finish;
  end

endmodule
